// ----- hw/rtl/plvq_pkg.sv -----
`timescale 1ns / 1ps
// plvq_pkg: widths, codes and shared types of the price level order queue
// used by plvq_pool, plvq_ctrl and price_level_order_queue_core; no dependencies
package plvq_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int PTR_W   = SLOT_W + 1;
  localparam int CNT_W   = PTR_W;
  localparam int QTY_W   = 32;
  localparam int AGG_W   = 48;
  localparam int SEQ_W   = 48;
  localparam int PRICE_W = 32;
  localparam int TYPE_W  = 2;
  localparam int STAT_W  = 4;

  // none marker for head, tail and links
  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(SLOTS);

  // request kinds
  localparam logic [TYPE_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_ERASE  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REDUCE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 4'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LEVEL  = 4'd1;
  localparam logic [STAT_W-1:0] ST_INVARIANT  = 4'd2;
  localparam logic [STAT_W-1:0] ST_NOT_MEMBER = 4'd3;
  localparam logic [STAT_W-1:0] ST_BAD_QTY    = 4'd4;
  localparam logic [STAT_W-1:0] ST_PRICE      = 4'd5;
  localparam logic [STAT_W-1:0] ST_LINKED     = 4'd6;
  localparam logic [STAT_W-1:0] ST_BAD_SEQ    = 4'd7;
  localparam logic [STAT_W-1:0] ST_NONMONO    = 4'd8;
  localparam logic [STAT_W-1:0] ST_AGG_OVER   = 4'd9;
  localparam logic [STAT_W-1:0] ST_BAD_RED    = 4'd11;

  // stream packing
  localparam int IN_SLOT_LSB  = 0;
  localparam int IN_PRICE_LSB = IN_SLOT_LSB + SLOT_W;
  localparam int IN_AMT_LSB   = IN_PRICE_LSB + PRICE_W;
  localparam int IN_SEQ_LSB   = IN_AMT_LSB + QTY_W;
  localparam int IN_BITS      = IN_SEQ_LSB + SEQ_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_CNT_LSB  = 0;
  localparam int OUT_AGG_LSB  = OUT_CNT_LSB + CNT_W;
  localparam int OUT_HEAD_LSB = OUT_AGG_LSB + AGG_W;
  localparam int OUT_TAIL_LSB = OUT_HEAD_LSB + PTR_W;
  localparam int OUT_REM_LSB  = OUT_TAIL_LSB + PTR_W;
  localparam int OUT_BITS     = OUT_REM_LSB + QTY_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [SLOT_W-1:0]  slot;
    logic [PRICE_W-1:0] order_price;
    logic [QTY_W-1:0]   amount;
    logic [SEQ_W-1:0]   priority_seq;
  } req_t;

  // pool entry read at the addressed slot
  typedef struct packed {
    logic [QTY_W-1:0] qty;
    logic [PTR_W-1:0] prev;
    logic [PTR_W-1:0] next;
    logic [SEQ_W-1:0] prev_seq;
  } slot_rd_t;

  // one write port per pool array
  typedef struct packed {
    logic              qty_we;
    logic [SLOT_W-1:0] qty_addr;
    logic [QTY_W-1:0]  qty_data;
    logic              prev_we;
    logic [SLOT_W-1:0] prev_addr;
    logic [PTR_W-1:0]  prev_data;
    logic              next_we;
    logic [SLOT_W-1:0] next_addr;
    logic [PTR_W-1:0]  next_data;
    logic              pseq_we;
    logic [SLOT_W-1:0] pseq_addr;
    logic [SEQ_W-1:0]  pseq_data;
  } pool_wr_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  order_count;
    logic [AGG_W-1:0]  aggregate_qty;
    logic [PTR_W-1:0]  head_slot;
    logic [PTR_W-1:0]  tail_slot;
    logic [QTY_W-1:0]  slot_remaining;
  } rsp_t;

endpackage

// ----- hw/rtl/plvq_pool.sv -----
`timescale 1ns / 1ps
// plvq_pool: order slot pool memories (quantity, links, sequence of predecessor)
// depends on plvq_pkg
module plvq_pool (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [plvq_pkg::SLOT_W-1:0] rd_addr_i,
  input  plvq_pkg::pool_wr_t        wr_i,
  output plvq_pkg::slot_rd_t        rd_o
);

  logic [plvq_pkg::QTY_W-1:0] qty_mem  [plvq_pkg::SLOTS];
  logic [plvq_pkg::PTR_W-1:0] prev_mem [plvq_pkg::SLOTS];
  logic [plvq_pkg::PTR_W-1:0] next_mem [plvq_pkg::SLOTS];
  logic [plvq_pkg::SEQ_W-1:0] pseq_mem [plvq_pkg::SLOTS];

  plvq_pkg::slot_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.qty_we) begin
      qty_mem[wr_i.qty_addr] <= wr_i.qty_data;
    end
    if (wr_i.prev_we) begin
      prev_mem[wr_i.prev_addr] <= wr_i.prev_data;
    end
    if (wr_i.next_we) begin
      next_mem[wr_i.next_addr] <= wr_i.next_data;
    end
    if (wr_i.pseq_we) begin
      pseq_mem[wr_i.pseq_addr] <= wr_i.pseq_data;
    end
  end

  // registered read at the slot of the accepted item
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.qty      <= qty_mem[rd_addr_i];
      rd_q.prev     <= prev_mem[rd_addr_i];
      rd_q.next     <= next_mem[rd_addr_i];
      rd_q.prev_seq <= pseq_mem[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

// ----- hw/rtl/plvq_ctrl.sv -----
`timescale 1ns / 1ps
// plvq_ctrl: level registers, request checks and list update for one item
// depends on plvq_pkg
module plvq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [plvq_pkg::PRICE_W-1:0] level_price_i,
  input  plvq_pkg::req_t               req_i,
  input  plvq_pkg::slot_rd_t           rd_i,
  output plvq_pkg::pool_wr_t           wr_o,
  output plvq_pkg::rsp_t               rsp_o
);

  logic [plvq_pkg::SLOTS-1:0]   linked_q, linked_d;
  logic [plvq_pkg::PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [plvq_pkg::CNT_W-1:0]   count_q, count_d;
  logic [plvq_pkg::AGG_W-1:0]   agg_q, agg_d;
  logic [plvq_pkg::SEQ_W-1:0]   tail_seq_q, tail_seq_d;
  logic [plvq_pkg::PRICE_W-1:0] group_price_q, group_price_d;

  logic [plvq_pkg::STAT_W-1:0]  lvl_st, st;
  logic [plvq_pkg::PTR_W-1:0]   s_ptr, p_ptr, n_ptr;
  logic [plvq_pkg::AGG_W:0]     sum;
  logic                         linked_s;
  plvq_pkg::pool_wr_t           wr;

  assign s_ptr    = {1'b0, req_i.slot};
  assign linked_s = linked_q[req_i.slot];
  // neighbors of the addressed slot; ends of the list read as none
  assign p_ptr    = (head_q == s_ptr) ? plvq_pkg::NONE_PTR : rd_i.prev;
  assign n_ptr    = (tail_q == s_ptr) ? plvq_pkg::NONE_PTR : rd_i.next;
  assign sum      = {1'b0, agg_q} + (plvq_pkg::AGG_W + 1)'(req_i.amount);

  // all resting orders share one price, so head and tail checks collapse into one
  always_comb begin
    if (level_price_i == '0) begin
      lvl_st = plvq_pkg::ST_BAD_LEVEL;
    end else if (count_q != '0 && group_price_q != level_price_i) begin
      lvl_st = plvq_pkg::ST_INVARIANT;
    end else begin
      lvl_st = plvq_pkg::ST_OK;
    end
  end

  always_comb begin
    st            = plvq_pkg::ST_OK;
    linked_d      = linked_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    agg_d         = agg_q;
    tail_seq_d    = tail_seq_q;
    group_price_d = group_price_q;
    wr            = '0;
    unique case (req_i.req_type)
      plvq_pkg::REQ_APPEND: begin
        if (lvl_st != plvq_pkg::ST_OK) begin
          st = lvl_st;
        end else if (req_i.amount == '0) begin
          st = plvq_pkg::ST_BAD_QTY;
        end else if (req_i.order_price != level_price_i) begin
          st = plvq_pkg::ST_PRICE;
        end else if (linked_s) begin
          st = plvq_pkg::ST_LINKED;
        end else if (req_i.priority_seq == '0) begin
          st = plvq_pkg::ST_BAD_SEQ;
        end else if (count_q != '0 && req_i.priority_seq <= tail_seq_q) begin
          st = plvq_pkg::ST_NONMONO;
        end else if (sum[plvq_pkg::AGG_W]) begin
          st = plvq_pkg::ST_AGG_OVER;
        end else begin
          linked_d[req_i.slot] = 1'b1;
          wr.qty_we    = 1'b1;
          wr.qty_addr  = req_i.slot;
          wr.qty_data  = req_i.amount;
          wr.prev_we   = 1'b1;
          wr.prev_addr = req_i.slot;
          wr.prev_data = tail_q;
          wr.pseq_we   = 1'b1;
          wr.pseq_addr = req_i.slot;
          wr.pseq_data = tail_seq_q;
          if (tail_q == plvq_pkg::NONE_PTR) begin
            head_d = s_ptr;
          end else begin
            wr.next_we   = 1'b1;
            wr.next_addr = tail_q[plvq_pkg::SLOT_W-1:0];
            wr.next_data = s_ptr;
          end
          tail_d        = s_ptr;
          tail_seq_d    = req_i.priority_seq;
          agg_d         = sum[plvq_pkg::AGG_W-1:0];
          count_d       = count_q + plvq_pkg::CNT_W'(1);
          group_price_d = req_i.order_price;
        end
      end
      plvq_pkg::REQ_ERASE: begin
        if (lvl_st != plvq_pkg::ST_OK) begin
          st = lvl_st;
        end else if (!linked_s) begin
          st = plvq_pkg::ST_NOT_MEMBER;
        end else begin
          if (p_ptr != plvq_pkg::NONE_PTR) begin
            wr.next_we   = 1'b1;
            wr.next_addr = p_ptr[plvq_pkg::SLOT_W-1:0];
            wr.next_data = n_ptr;
          end else begin
            head_d = n_ptr;
          end
          if (n_ptr != plvq_pkg::NONE_PTR) begin
            wr.prev_we   = 1'b1;
            wr.prev_addr = n_ptr[plvq_pkg::SLOT_W-1:0];
            wr.prev_data = p_ptr;
            wr.pseq_we   = 1'b1;
            wr.pseq_addr = n_ptr[plvq_pkg::SLOT_W-1:0];
            wr.pseq_data = rd_i.prev_seq;
          end else begin
            tail_d     = p_ptr;
            tail_seq_d = rd_i.prev_seq;
          end
          linked_d[req_i.slot] = 1'b0;
          agg_d   = agg_q - plvq_pkg::AGG_W'(rd_i.qty);
          count_d = count_q - plvq_pkg::CNT_W'(1);
        end
      end
      plvq_pkg::REQ_REDUCE: begin
        if (lvl_st != plvq_pkg::ST_OK) begin
          st = lvl_st;
        end else if (!linked_s) begin
          st = plvq_pkg::ST_NOT_MEMBER;
        end else if (req_i.amount == '0 || req_i.amount >= rd_i.qty) begin
          st = plvq_pkg::ST_BAD_RED;
        end else begin
          wr.qty_we   = 1'b1;
          wr.qty_addr = req_i.slot;
          wr.qty_data = rd_i.qty - req_i.amount;
          agg_d       = agg_q - plvq_pkg::AGG_W'(req_i.amount);
        end
      end
      default: begin
        // unknown kind: no change, totals reported
        st = plvq_pkg::ST_OK;
      end
    endcase
  end

  assign wr_o = go_i ? wr : '0;

  always_comb begin
    rsp_o.status        = st;
    rsp_o.order_count   = count_d;
    rsp_o.aggregate_qty = agg_d;
    rsp_o.head_slot     = head_d;
    rsp_o.tail_slot     = tail_d;
    if (linked_d[req_i.slot]) begin
      rsp_o.slot_remaining = wr.qty_we ? wr.qty_data : rd_i.qty;
    end else begin
      rsp_o.slot_remaining = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linked_q <= '0;
      head_q   <= plvq_pkg::NONE_PTR;
      tail_q   <= plvq_pkg::NONE_PTR;
      count_q  <= '0;
      agg_q    <= '0;
    end else if (go_i) begin
      linked_q <= linked_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      agg_q    <= agg_d;
    end
  end

  // not reset; their values only matter while the level holds orders
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      tail_seq_q    <= tail_seq_d;
      group_price_q <= group_price_d;
    end
  end

endmodule

// ----- hw/rtl/price_level_order_queue_core.sv -----
`timescale 1ns / 1ps
// price_level_order_queue_core: top level of the price level order queue
// depends on plvq_pkg, plvq_pool and plvq_ctrl
//
// usage
//   s_axis carries requests: append, erase or reduce against one order slot.
//   m_axis returns one result item per request: status and level totals.
//   apb port holds level_price at byte address 0; write it only while idle.
// timing
//   an item is accepted into the request register while the slot pool is
//   read at its slot; the next cycle checks it, writes the pool and the
//   level registers and loads the result register.
//   the result is shown the cycle after that.
//   no new item is accepted while one is in work, because of the read then
//   write of the pool around each request.
// reset
//   rst_ni clears the level: no linked slots, head and tail none, count and
//   aggregate zero, level_price zero. the pool needs no clearing.
// stall
//   a result held by m_axis_tready_i low keeps s_axis_tready_o low, so no
//   item is lost or overwritten.
module price_level_order_queue_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata from bit 0: slot, order_price, amount, priority_seq, zero fill
  input  logic [plvq_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: req_type
  input  logic [plvq_pkg::TYPE_W-1:0]     s_axis_tuser_i,
  // result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata from bit 0: order_count, aggregate_qty, head_slot, tail_slot,
  // slot_remaining, zero fill
  output logic [plvq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status
  output logic [plvq_pkg::STAT_W-1:0]     m_axis_tuser_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // register index sits above the byte offset
  localparam logic REG_LEVEL_PRICE = 1'b0;

  logic [plvq_pkg::PRICE_W-1:0] level_price_q;
  logic                         busy_q;
  logic                         out_valid_q;
  logic                         in_accept;
  plvq_pkg::req_t               req_q;
  plvq_pkg::rsp_t               rsp, out_rsp_q;
  plvq_pkg::slot_rd_t           pool_rd;
  plvq_pkg::pool_wr_t           pool_wr;

  // apb: pready tied high, one register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LEVEL_PRICE) ? level_price_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_price_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LEVEL_PRICE) begin
      level_price_q <= pwdata;
    end
  end

  // accept when no item is in work and the result register frees in time
  assign s_axis_tready_o = !busy_q && (!out_valid_q || m_axis_tready_i);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= in_accept;
    end
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.req_type     <= s_axis_tuser_i;
      req_q.slot         <= s_axis_tdata_i[plvq_pkg::IN_SLOT_LSB +: plvq_pkg::SLOT_W];
      req_q.order_price  <= s_axis_tdata_i[plvq_pkg::IN_PRICE_LSB +: plvq_pkg::PRICE_W];
      req_q.amount       <= s_axis_tdata_i[plvq_pkg::IN_AMT_LSB +: plvq_pkg::QTY_W];
      req_q.priority_seq <= s_axis_tdata_i[plvq_pkg::IN_SEQ_LSB +: plvq_pkg::SEQ_W];
    end
  end

  plvq_pool u_pool (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (s_axis_tdata_i[plvq_pkg::IN_SLOT_LSB +: plvq_pkg::SLOT_W]),
    .wr_i      (pool_wr),
    .rd_o      (pool_rd)
  );

  plvq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (busy_q),
    .level_price_i (level_price_q),
    .req_i         (req_q),
    .rd_i          (pool_rd),
    .wr_o          (pool_wr),
    .rsp_o         (rsp)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (busy_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      out_rsp_q <= rsp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_rsp_q.status;
  assign m_axis_tdata_o  = {
    (plvq_pkg::OUT_TDATA_W - plvq_pkg::OUT_BITS)'(0),
    out_rsp_q.slot_remaining,
    out_rsp_q.tail_slot,
    out_rsp_q.head_slot,
    out_rsp_q.aggregate_qty,
    out_rsp_q.order_count
  };

`ifndef SYNTHESIS
  // work on an item ends before another can start: busy_q clears after each item
  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("request stayed in work for more than one cycle");

  // a stalled result blocks new requests
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("request accepted while result stalled");

  // every accepted item passes the request register and then shows a result from the result register
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> ##1 m_axis_tvalid_o)
    else $error("result missing after accepted request");

  // an empty level reports no head, and a nonempty one reports a head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((out_rsp_q.order_count == '0) == (out_rsp_q.head_slot == plvq_pkg::NONE_PTR)))
    else $error("order count and head slot disagree");
`endif

endmodule

// ----- verif/plvq_checker.sv -----
`timescale 1ns / 1ps
// plvq_checker: watches the request, result and apb channels of the price level
// order queue, predicts every result and compares it; depends on plvq_pkg
module plvq_checker
  import plvq_pkg::*;
#(
  parameter logic [2:0] PRICE_ADDR = 3'd0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [TYPE_W-1:0]      s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [STAT_W-1:0]      m_tuser_i,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [2:0]             paddr_i,
  input  logic [31:0]            pwdata_i,
  input  logic [31:0]            prdata_i,
  input  logic                   pready_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  // not exported by the package
  localparam logic [STAT_W-1:0] ST_AGG_UNDER = 4'd10;
  localparam logic [AGG_W-1:0]  AGG_MAX      = '1;
  localparam logic [PTR_W-1:0]  POOL_END     = PTR_W'(SLOTS);

  logic [PRICE_W-1:0] level_price;
  logic               slot_used  [SLOTS];
  logic [QTY_W-1:0]   rest_qty   [SLOTS];
  logic [SEQ_W-1:0]   rest_seq   [SLOTS];
  logic [PRICE_W-1:0] rest_price [SLOTS];
  logic [PTR_W-1:0]   older      [SLOTS];
  logic [PTR_W-1:0]   newer      [SLOTS];
  logic [PTR_W-1:0]   oldest;
  logic [PTR_W-1:0]   newest;
  logic [CNT_W-1:0]   resting;
  logic [AGG_W-1:0]   total_qty;
  rsp_t               expected_q [$];

  // consistency of the level totals and end prices
  function automatic logic [STAT_W-1:0] level_status();
    if (level_price == '0) return ST_BAD_LEVEL;
    if (resting == '0) begin
      return (oldest != NONE_PTR || newest != NONE_PTR || total_qty != '0) ?
             ST_INVARIANT : ST_OK;
    end
    if (oldest >= POOL_END || newest >= POOL_END || total_qty == '0) return ST_INVARIANT;
    if (rest_price[oldest[SLOT_W-1:0]] != level_price ||
        rest_price[newest[SLOT_W-1:0]] != level_price) return ST_INVARIANT;
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] member_status(logic [SLOT_W-1:0] s);
    logic [STAT_W-1:0] st;
    st = level_status();
    if (st != ST_OK) return st;
    if (!slot_used[s]) return ST_NOT_MEMBER;
    if (rest_price[s] != level_price || rest_qty[s] == '0 || rest_seq[s] == '0)
      return ST_INVARIANT;
    return ST_OK;
  endfunction

  // applies one request to the shadow level and returns the result it reports
  function automatic rsp_t apply_request(req_t r);
    rsp_t              res;
    logic [SLOT_W-1:0] s;
    logic [PTR_W-1:0]  p;
    logic [PTR_W-1:0]  n;
    logic [AGG_W-1:0]  left;
    logic [STAT_W-1:0] st;
    s  = r.slot;
    st = ST_OK;
    case (r.req_type)
      REQ_APPEND: begin
        st = level_status();
        if (st == ST_OK) begin
          if (r.amount == '0) st = ST_BAD_QTY;
          else if (r.order_price != level_price) st = ST_PRICE;
          else if (slot_used[s]) st = ST_LINKED;
          else if (r.priority_seq == '0) st = ST_BAD_SEQ;
          else if (newest < POOL_END && r.priority_seq <= rest_seq[newest[SLOT_W-1:0]])
            st = ST_NONMONO;
          else if (AGG_W'(r.amount) > AGG_MAX - total_qty) st = ST_AGG_OVER;
          else begin
            slot_used[s]  = 1'b1;
            rest_qty[s]   = r.amount;
            rest_seq[s]   = r.priority_seq;
            rest_price[s] = r.order_price;
            older[s]      = newest;
            newer[s]      = NONE_PTR;
            if (newest < POOL_END) newer[newest[SLOT_W-1:0]] = PTR_W'(s);
            else oldest = PTR_W'(s);
            newest    = PTR_W'(s);
            total_qty = total_qty + AGG_W'(r.amount);
            resting   = resting + CNT_W'(1);
          end
        end
      end
      REQ_ERASE: begin
        st = member_status(s);
        if (st == ST_OK) begin
          left = total_qty - AGG_W'(rest_qty[s]);
          if (resting == '0) st = ST_INVARIANT;
          else if (AGG_W'(rest_qty[s]) > total_qty) st = ST_AGG_UNDER;
          else if ((resting == CNT_W'(1)) != (left == '0)) st = ST_INVARIANT;
          else begin
            p = older[s];
            n = newer[s];
            if (p < POOL_END) newer[p[SLOT_W-1:0]] = n;
            else oldest = n;
            if (n < POOL_END) older[n[SLOT_W-1:0]] = p;
            else newest = p;
            total_qty    = left;
            resting      = resting - CNT_W'(1);
            slot_used[s] = 1'b0;
            older[s]     = NONE_PTR;
            newer[s]     = NONE_PTR;
          end
        end
      end
      REQ_REDUCE: begin
        st = member_status(s);
        if (st == ST_OK) begin
          if (r.amount == '0 || r.amount >= rest_qty[s]) st = ST_BAD_RED;
          else if (AGG_W'(r.amount) > total_qty) st = ST_AGG_UNDER;
          else if (total_qty - AGG_W'(r.amount) == '0) st = ST_INVARIANT;
          else begin
            rest_qty[s] = rest_qty[s] - r.amount;
            total_qty   = total_qty - AGG_W'(r.amount);
          end
        end
      end
      default: ;
    endcase
    res.status         = st;
    res.order_count    = resting;
    res.aggregate_qty  = total_qty;
    res.head_slot      = oldest;
    res.tail_slot      = newest;
    res.slot_remaining = slot_used[s] ? rest_qty[s] : '0;
    return res;
  endfunction

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    req_t req;
    rsp_t got;
    rsp_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      level_price = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i]  = 1'b0;
        rest_qty[i]   = '0;
        rest_seq[i]   = '0;
        rest_price[i] = '0;
        older[i]      = NONE_PTR;
        newer[i]      = NONE_PTR;
      end
      oldest    = NONE_PTR;
      newest    = NONE_PTR;
      resting   = '0;
      total_qty = '0;
      expected_q.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == PRICE_ADDR) begin
        if (pwrite_i) level_price = pwdata_i;
        else check_field("prdata level_price", 64'(level_price), 64'(prdata_i));
      end
      if (s_tvalid_i && s_tready_i) begin
        req.req_type     = s_tuser_i;
        req.slot         = s_tdata_i[IN_SLOT_LSB +: SLOT_W];
        req.order_price  = s_tdata_i[IN_PRICE_LSB +: PRICE_W];
        req.amount       = s_tdata_i[IN_AMT_LSB +: QTY_W];
        req.priority_seq = s_tdata_i[IN_SEQ_LSB +: SEQ_W];
        expected_q.push_back(apply_request(req));
      end
      if (m_tvalid_i && m_tready_i) begin
        got.status         = m_tuser_i;
        got.order_count    = m_tdata_i[OUT_CNT_LSB +: CNT_W];
        got.aggregate_qty  = m_tdata_i[OUT_AGG_LSB +: AGG_W];
        got.head_slot      = m_tdata_i[OUT_HEAD_LSB +: PTR_W];
        got.tail_slot      = m_tdata_i[OUT_TAIL_LSB +: PTR_W];
        got.slot_remaining = m_tdata_i[OUT_REM_LSB +: QTY_W];
        if (expected_q.size() == 0) begin
          $display("%0t ns: result with none outstanding, expected nothing actual %0h",
                   $time, got);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("order_count", 64'(want.order_count), 64'(got.order_count));
          check_field("aggregate_qty", 64'(want.aggregate_qty), 64'(got.aggregate_qty));
          check_field("head_slot", 64'(want.head_slot), 64'(got.head_slot));
          check_field("tail_slot", 64'(want.tail_slot), 64'(got.tail_slot));
          check_field("slot_remaining", 64'(want.slot_remaining),
                      64'(got.slot_remaining));
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ----- verif/price_level_order_queue_core_tb.sv -----
`timescale 1ns / 1ps
// price_level_order_queue_core_tb: stimulus and verdict for the price level order queue
// depends on plvq_pkg, price_level_order_queue_core and plvq_checker
module price_level_order_queue_core_tb;
  import plvq_pkg::*;

  localparam logic [2:0]        LEVEL_PRICE_ADDR = 3'd0;
  // request kind the block ignores
  localparam logic [TYPE_W-1:0] REQ_UNUSED       = 2'd3;
  localparam logic [PRICE_W-1:0] PRICE_TOP       = '1;
  localparam logic [QTY_W-1:0]  QTY_TOP          = '1;
  localparam logic [SEQ_W-1:0]  SEQ_TOP          = '1;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 86;
  // slowest run is far below this, with ~1850 items
  localparam int CYCLE_LIMIT     = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic [TYPE_W-1:0]      s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [STAT_W-1:0]      m_axis_tuser_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  int                     fail_count;
  int                     pending;
  int                     cycles = 0;
  // phase with no idling on either side
  bit                     quiet = 1'b0;
  // running time priority; only grows within a phase
  logic [SEQ_W-1:0]       next_seq;
  logic [SLOT_W-1:0]      slot_cursor = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  price_level_order_queue_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // prediction and comparison live in the checker; it reports failures and
  // the number of results still outstanding
  plvq_checker #(.PRICE_ADDR(LEVEL_PRICE_ADDR)) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_i  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tvalid_i  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_i   (m_axis_tdata_o),
    .m_tuser_i   (m_axis_tuser_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one request item; drives at the falling edge, holds until accepted at a
  // rising edge, leaves tvalid high so a back-to-back item needs no toggle
  task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                          input logic [PRICE_W-1:0] price, input logic [QTY_W-1:0] amt,
                          input logic [SEQ_W-1:0] seq);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    word = '0;
    word[IN_SLOT_LSB +: SLOT_W]   = slot;
    word[IN_PRICE_LSB +: PRICE_W] = price;
    word[IN_AMT_LSB +: QTY_W]     = amt;
    word[IN_SEQ_LSB +: SEQ_W]     = seq;
    s_axis_tdata_i  = word;
    s_axis_tuser_i  = kind;
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every result is back, so the block is idle
  task automatic wait_idle();
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // apb write of level_price, then a read back that the checker compares
  task automatic set_level_price(input logic [PRICE_W-1:0] value);
    for (int rd = 0; rd < 2; rd++) begin
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = (rd == 0);
      paddr   = LEVEL_PRICE_ADDR;
      pwdata  = value;
      @(negedge clk_i);
      penable = 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      @(negedge clk_i);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
    end
  endtask

  // one random request: mostly well-formed appends at the level price with
  // rising priority, erases and small reductions; the rest is noise
  task automatic random_item(input int append_pct, input logic [PRICE_W-1:0] price);
    int                 r;
    int                 pick;
    logic [SLOT_W-1:0]  slot;
    logic [PRICE_W-1:0] p;
    logic [QTY_W-1:0]   amt;
    logic [SEQ_W-1:0]   seq;
    r    = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    slot = SLOT_W'($urandom_range(0, SLOTS - 1));
    if (r < append_pct) begin
      // walking slot fills the pool quickly in append-heavy phases
      if ($urandom_range(0, 9) < 7) begin
        slot        = slot_cursor;
        slot_cursor = slot_cursor + SLOT_W'(1);
      end
      amt      = (pick < 15) ? QTY_W'($urandom_range(1, 255)) : QTY_W'($urandom);
      next_seq = next_seq + SEQ_W'($urandom_range(1, 16));
      seq      = next_seq;
      p        = price;
      if (pick >= 88 && pick < 92) p = $urandom;
      else if (pick >= 92 && pick < 94) seq = '0;
      else if (pick >= 94 && pick < 96) seq = next_seq - SEQ_W'($urandom_range(0, 40));
      else if (pick >= 96) amt = '0;
      send_req(REQ_APPEND, slot, p, amt, seq);
    end else if (r < 97) begin
      if ($urandom_range(0, 1)) begin
        send_req(REQ_ERASE, slot, $urandom, $urandom, {16'($urandom), 32'($urandom)});
      end else begin
        if (pick < 60) amt = $urandom_range(1, 1000);
        else if (pick < 75) amt = '0;
        else amt = $urandom;
        send_req(REQ_REDUCE, slot, $urandom, amt, {16'($urandom), 32'($urandom)});
      end
    end else begin
      send_req(REQ_UNUSED, slot, $urandom, $urandom, {16'($urandom), 32'($urandom)});
    end
  endtask

  // result side: random stall before each result, none in quiet phases
  initial begin
    int wait_cycles;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      wait_cycles = quiet ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [PRICE_W-1:0] price;
    int                 append_pct;
    int                 start;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_APPEND;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = LEVEL_PRICE_ADDR;
    pwdata          = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // level price still zero after reset: everything is rejected
    send_req(REQ_APPEND, 6'd0, PRICE_TOP, QTY_TOP, 48'd1);
    send_req(REQ_ERASE, 6'd0, '0, '0, '0);
    send_req(REQ_REDUCE, 6'd0, '0, 32'd1, '0);

    // top price level; append checks but aggregate overflow, in order of precedence
    wait_idle();
    set_level_price(PRICE_TOP);
    send_req(REQ_APPEND, 6'd0, PRICE_TOP, QTY_TOP, 48'd1);
    send_req(REQ_APPEND, 6'd63, PRICE_TOP, '0, 48'd2);
    send_req(REQ_APPEND, 6'd63, '0, 32'd5, 48'd2);
    send_req(REQ_APPEND, 6'd0, PRICE_TOP, 32'd5, 48'd2);
    send_req(REQ_APPEND, 6'd63, PRICE_TOP, 32'd5, '0);
    send_req(REQ_APPEND, 6'd63, PRICE_TOP, 32'd5, 48'd1);
    send_req(REQ_APPEND, 6'd63, PRICE_TOP, 32'd1, SEQ_TOP);
    // reductions: zero, equal to the rest, largest legal, against a qty of one
    send_req(REQ_REDUCE, 6'd0, '0, '0, '0);
    send_req(REQ_REDUCE, 6'd0, '0, QTY_TOP, '0);
    send_req(REQ_REDUCE, 6'd0, '0, QTY_TOP - QTY_W'(1), '0);
    send_req(REQ_REDUCE, 6'd63, '0, 32'd1, '0);
    // slot that is not resting here
    send_req(REQ_REDUCE, 6'd5, '0, 32'd1, '0);
    send_req(REQ_ERASE, 6'd5, '0, '0, '0);
    // unknown kind only reports the totals
    send_req(REQ_UNUSED, 6'd0, PRICE_TOP, QTY_TOP, SEQ_TOP);

    // level repriced while orders rest: the level reads as broken
    wait_idle();
    set_level_price(32'd1);
    send_req(REQ_ERASE, 6'd0, '0, '0, '0);
    send_req(REQ_APPEND, 6'd5, 32'd1, 32'd7, SEQ_TOP);
    send_req(REQ_REDUCE, 6'd63, '0, 32'd1, '0);
    wait_idle();
    set_level_price(PRICE_TOP);
    // erase tail then head, leaving the level empty
    send_req(REQ_ERASE, 6'd63, '0, '0, '0);
    send_req(REQ_ERASE, 6'd0, '0, '0, '0);

    // random phases, each at its own level price and mix
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       price = 32'd1;
        1:       price = PRICE_TOP;
        default: begin
          price = $urandom;
          if (price == '0) price = 32'd2;
        end
      endcase
      wait_idle();
      set_level_price(price);
      quiet      = ($urandom_range(0, 3) == 0);
      // level is empty here, so the priority can restart anywhere
      next_seq   = {8'($urandom_range(0, 254)), 32'($urandom), 8'($urandom)};
      append_pct = (ph % 4 == 1) ? 92 : $urandom_range(30, 80);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_item(append_pct, price);
        // mid-phase repricing, sometimes to zero, then back
        if (ph % 3 == 2 && i == ITEMS_PER_PHASE / 2) begin
          wait_idle();
          set_level_price($urandom_range(0, 1) ? '0 : price ^ ($urandom | 32'd1));
          repeat (8) random_item(append_pct, price);
          wait_idle();
          set_level_price(price);
        end
      end
      // empty the level so the next phase starts clean
      start = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
        send_req(REQ_ERASE, SLOT_W'(start + k), $urandom, $urandom, '0);
      end
    end

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
